// ===== sv/sdl_pkg.sv =====
// Shared types and codes for the sorted double-ended list.
// Used by sdl_cell, sorted_deque_list and the testbench; depends on nothing else.
`default_nettype none

package sdl_pkg;

  // Operation codes carried in the mode field of an input beat.
  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_ORDERED    = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_POP_BACK   = 3'd4,
    MODE_PEEK_FRONT = 3'd5,
    MODE_PEEK_BACK  = 3'd6
  } mode_t;

  // Status codes returned with every result beat.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // One-cycle commands broadcast from the controller to every cell.
  typedef struct packed {
    logic shift_left;  // every cell takes its right neighbor's value
    logic write_tail;  // the cell at the fill count takes the new value
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/sdl_cell.sv =====
// One storage cell of the list chain: holds one entry, runs the insert wave
// and the tail-read wave. Depends on sdl_pkg.
`default_nettype none

module sdl_cell
  import sdl_pkg::*;
#(
  parameter int IDX = 0,
  parameter int W   = 32,
  parameter int CW  = 5
) (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  cell_ctrl_t          ctrl,
  input  wire  logic [CW-1:0]       count,
  input  wire  logic signed [W-1:0] wr_value,
  input  wire  logic signed [W-1:0] right_val,
  input  wire  logic                tok_in,
  input  wire  logic                ins_in,
  input  wire  logic signed [W-1:0] carry_in,
  output logic                      tok_out,
  output logic                      ins_out,
  output logic signed [W-1:0]       carry_out,
  input  wire  logic signed [W-1:0] bk_in,
  output logic signed [W-1:0]       bk_out,
  output logic signed [W-1:0]       val
);

  logic holds;
  logic take;

  // The cell holds a live entry when its index is below the fill count.
  assign holds = CW'(IDX) < count;

  // The passing value drops in here once the insert point is reached; from then
  // on every cell swaps, so the displaced entries move one place toward the back.
  assign take = tok_in && (ins_in || !holds || !(val > carry_in));

  // The wave token stops at the first empty cell, where the insert always lands.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in && holds;
    end
  end

  // Carried value and insert flag for the next cell.
  always_ff @(posedge clk) begin
    ins_out   <= ins_in || take;
    carry_out <= take ? val : carry_in;
  end

  // Entry update: insert wave, front removal, or write at the tail.
  always_ff @(posedge clk) begin
    priority if (take) begin
      val <= carry_in;
    end else if (ctrl.shift_left) begin
      val <= right_val;
    end else if (ctrl.write_tail && (CW'(IDX) == count)) begin
      val <= wr_value;
    end else begin
      val <= val;
    end
  end

  // Tail-read wave: the last live cell injects its value, which moves toward
  // the front one cell per cycle.
  always_ff @(posedge clk) begin
    bk_out <= (CW'(IDX + 1) == count) ? val : bk_in;
  end

endmodule

`default_nettype wire

// ===== sv/sorted_deque_list.sv =====
// Top level of the sorted double-ended list: controller, result register and
// the chain of sdl_cell instances. Depends on sdl_pkg and sdl_cell.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   mode, item_value
//   out      source     out_valid/out_stall status, out_value, entry_count
//
// Push back, pop front, peek front and refused operations register their
// result at the accepting edge. Push front and ordered insert send a token that
// walks the cell chain one cell per cycle until it reaches the first empty cell.
// Pop back and peek back wait in ST_BACK while the tail value walks the
// chain toward the front. Reset (synchronous) empties the list at once.
// A result waits in the output register under out_stall; no new beat is taken
// while the controller is busy or a stalled result would be overwritten.
`default_nettype none

module sorted_deque_list
  import sdl_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire  logic               clk,
  input  wire  logic               rst,
  input  wire  logic               in_valid,
  output logic                     in_stall,
  input  wire  logic [2:0]         mode,
  input  wire  logic signed [31:0] item_value,
  output logic                     out_valid,
  input  wire  logic               out_stall,
  output logic [1:0]               status,
  output logic signed [31:0]       out_value,
  output logic [4:0]               entry_count
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_BACK,
    ST_FINISH
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [IW-1:0]       cnt;
  mode_t               op;
  logic signed [W-1:0] ins_val;
  logic                tok0;
  logic                ins0;

  logic                accept;
  logic                slot_free;
  logic                full;
  logic                empty;
  mode_t               in_mode;
  logic signed [W-1:0] in_w;
  logic signed [W-1:0] fin_w;
  logic [CW-1:0]       fin_count;
  cell_ctrl_t          ctrl;

  logic                tok   [DEPTH+1];
  logic                ins   [DEPTH+1];
  logic signed [W-1:0] carry [DEPTH+1];
  logic signed [W-1:0] bk    [DEPTH+1];
  logic signed [W-1:0] vals  [DEPTH+1];

  assign in_mode   = mode_t'(mode);
  assign in_w      = W'(item_value);
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign full      = count == CW'(DEPTH);
  assign empty     = count == '0;

  // One-cycle commands to the cells, taken at the accepting edge.
  assign ctrl.shift_left = accept && (in_mode == MODE_POP_FRONT) && !empty;
  assign ctrl.write_tail = accept && (in_mode == MODE_PUSH_BACK) && !full;

  // Value and new count of a result produced after a multi-cycle operation.
  assign fin_w = (op == MODE_PUSH_FRONT || op == MODE_ORDERED) ? ins_val : bk[0];
  always_comb begin
    unique case (op)
      MODE_PUSH_FRONT, MODE_ORDERED: fin_count = count + CW'(1);
      MODE_POP_BACK:                 fin_count = count - CW'(1);
      default:                       fin_count = count;
    endcase
  end

  // Head of the chains.
  assign tok[0]     = tok0;
  assign ins[0]     = ins0;
  assign carry[0]   = ins_val;
  assign bk[DEPTH]  = '0;
  assign vals[DEPTH] = '0;

  // The chain of cells, one entry each, front at index zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sdl_cell #(
      .IDX (i),
      .W   (W),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .count     (count),
      .wr_value  (in_w),
      .right_val (vals[i+1]),
      .tok_in    (tok[i]),
      .ins_in    (ins[i]),
      .carry_in  (carry[i]),
      .tok_out   (tok[i+1]),
      .ins_out   (ins[i+1]),
      .carry_out (carry[i+1]),
      .bk_in     (bk[i+1]),
      .bk_out    (bk[i]),
      .val       (vals[i])
    );
  end

  // Controller, fill count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      tok0      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      tok0 <= 1'b0;
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op      <= in_mode;
            ins_val <= in_w;
            cnt     <= '0;
            unique case (in_mode)
              MODE_PUSH_FRONT, MODE_ORDERED: begin
                if (full) begin
                  out_valid   <= 1'b1;
                  status      <= STATUS_FULL;
                  out_value   <= '0;
                  entry_count <= 5'(count);
                end else begin
                  tok0  <= 1'b1;
                  ins0  <= in_mode == MODE_PUSH_FRONT;
                  state <= ST_INSERT;
                end
              end
              MODE_PUSH_BACK: begin
                out_valid <= 1'b1;
                if (full) begin
                  status      <= STATUS_FULL;
                  out_value   <= '0;
                  entry_count <= 5'(count);
                end else begin
                  status      <= STATUS_OK;
                  out_value   <= 32'(in_w);
                  entry_count <= 5'(count + CW'(1));
                  count       <= count + CW'(1);
                end
              end
              MODE_POP_FRONT, MODE_PEEK_FRONT: begin
                out_valid <= 1'b1;
                if (empty) begin
                  status      <= STATUS_EMPTY;
                  out_value   <= '0;
                  entry_count <= 5'(count);
                end else if (in_mode == MODE_POP_FRONT) begin
                  status      <= STATUS_OK;
                  out_value   <= 32'(vals[0]);
                  entry_count <= 5'(count - CW'(1));
                  count       <= count - CW'(1);
                end else begin
                  status      <= STATUS_OK;
                  out_value   <= 32'(vals[0]);
                  entry_count <= 5'(count);
                end
              end
              MODE_POP_BACK, MODE_PEEK_BACK: begin
                if (empty) begin
                  out_valid   <= 1'b1;
                  status      <= STATUS_EMPTY;
                  out_value   <= '0;
                  entry_count <= 5'(count);
                end else begin
                  state <= ST_BACK;
                end
              end
              default: begin
                out_valid   <= 1'b1;
                status      <= STATUS_OK;
                out_value   <= '0;
                entry_count <= 5'(count);
              end
            endcase
          end
        end
        ST_INSERT: begin
          // The token is in the cell numbered cnt; the insert is complete once the
          // token has reached the cell at the fill count.
          cnt <= cnt + IW'(1);
          if (CW'(cnt) == count) begin
            state <= ST_FINISH;
          end
        end
        ST_BACK: begin
          cnt <= cnt + IW'(1);
          if (cnt == IW'(DEPTH - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            status      <= STATUS_OK;
            out_value   <= 32'(fin_w);
            entry_count <= 5'(fin_count);
            count       <= fin_count;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The list never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  // An insert token enters the chain only during an insert.
  a_tok_insert: assert property (@(posedge clk) disable iff (rst)
    tok[0] |-> state == ST_INSERT)
    else $error("insert token outside an insert");

  // The fill count moves only at an accepted beat or at the end of a long operation.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept && state != ST_FINISH |=> $stable(count))
    else $error("fill count changed without an operation");

  // A refused insert is reported only on a full list.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> entry_count == 5'(DEPTH))
    else $error("full status on a list that is not full");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for sorted_deque_list: random and directed list operations
// are checked against a queue-based model of the bounded descending list.
// Depends on sdl_pkg and the sorted_deque_list RTL.

module tb;
  import sdl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 16;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int DRAIN_CYCLES = 60;

  // Mode 7 carries no operation; the block answers it without touching the list.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  // Handshake phases: no idling, sender idle, receiver stalling, both.
  localparam int PH_FREE  = 0;
  localparam int PH_SEND  = 1;
  localparam int PH_RECV  = 2;
  localparam int PH_BOTH  = 3;
  localparam int N_PHASES = 4;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] value;
    int                 phase;
  } op_beat_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] value;
    logic [4:0]         count;
  } list_result_t;

  int in_idle_pct   [N_PHASES] = '{0, 88, 0, 28};
  int out_stall_pct [N_PHASES] = '{0, 0, 88, 28};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         mode = MODE_PUSH_FRONT;
  logic signed [31:0] item_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] out_value;
  logic [4:0]         entry_count;

  op_beat_t           pending_ops[$];
  list_result_t       expected_results[$];
  logic signed [31:0] list_model[$];

  int cur_phase = PH_FREE;
  int total_ops = 0;
  int accepted_ops = 0;
  int results_seen = 0;
  int mismatches = 0;
  int full_refusals = 0;
  int empty_answers = 0;
  int max_fill = 0;

  sorted_deque_list #(
    .DEPTH       (LIST_DEPTH),
    .VALUE_WIDTH (32)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_value   (out_value),
    .entry_count (entry_count)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the list model and return the result it should produce.
  function automatic list_result_t apply_op(input logic [2:0] op,
                                            input logic signed [31:0] v);
    list_result_t r;
    int pos;
    r.status = STATUS_OK;
    r.value  = '0;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_ORDERED: begin
        if (list_model.size() >= LIST_DEPTH) begin
          r.status = STATUS_FULL;
          full_refusals++;
        end else begin
          if (op == MODE_PUSH_FRONT) begin
            list_model.push_front(v);
          end else if (op == MODE_PUSH_BACK) begin
            list_model.push_back(v);
          end else begin
            // The new entry goes ahead of the first one not greater than it.
            pos = 0;
            while (pos < list_model.size() && list_model[pos] > v) pos++;
            list_model.insert(pos, v);
          end
          r.value = v;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        if (list_model.size() == 0) begin
          r.status = STATUS_EMPTY;
          empty_answers++;
        end else begin
          case (op)
            MODE_POP_FRONT:  r.value = list_model.pop_front();
            MODE_POP_BACK:   r.value = list_model.pop_back();
            MODE_PEEK_FRONT: r.value = list_model[0];
            default:         r.value = list_model[list_model.size() - 1];
          endcase
        end
      end
      default: ;
    endcase
    r.count = 5'(list_model.size());
    if (list_model.size() > max_fill) max_fill = list_model.size();
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic add_op(input logic [2:0] op, input logic signed [31:0] v, input int phase);
    op_beat_t b;
    b.op    = op;
    b.value = v;
    b.phase = phase;
    pending_ops.push_back(b);
    total_ops++;
  endtask

  // Values lean toward extremes and a narrow band so that equal keys are common.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       v = 32'sh7fff_ffff;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          default: v = -32'sd1;
        endcase
      end
      1, 2:    v = $signed($urandom_range(8)) - 32'sd4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Filling stretches favor inserts; draining stretches favor removes and reads.
  function automatic logic [2:0] pick_mode(input bit filling);
    int r;
    r = $urandom_range(99);
    if (r < 3) return MODE_UNUSED;
    if (r < (filling ? 80 : 25)) return 3'($urandom_range(MODE_PUSH_FRONT, MODE_ORDERED));
    return 3'($urandom_range(MODE_POP_FRONT, MODE_PEEK_BACK));
  endfunction

  // Driver: present the next pending beat once the current one has been taken.
  always @(posedge clk) begin : drive_ops
    op_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_ops.size() != 0 &&
          $urandom_range(99) >= in_idle_pct[pending_ops[0].phase]) begin
        nxt = pending_ops.pop_front();
        in_valid   <= 1'b1;
        mode       <= nxt.op;
        item_value <= nxt.value;
        cur_phase  <= nxt.phase;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure follows the current phase.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct[cur_phase]);
    end
  end

  // Monitor: check each result beat, then log any input beat taken on this edge.
  always @(posedge clk) begin : watch_ops
    list_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no operation outstanding");
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status, want.status));
          if (out_value !== want.value)
            report_mismatch($sformatf("out_value got %0d want %0d", out_value, want.value));
          if (entry_count !== want.count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      entry_count, want.count));
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_op(mode, item_value));
        accepted_ops++;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    bit filling;
    int stretch;

    // Directed: empty-list answers, the unused mode, extremes and equal keys.
    add_op(MODE_POP_FRONT,  '0, PH_FREE);
    add_op(MODE_POP_BACK,   '0, PH_FREE);
    add_op(MODE_PEEK_FRONT, '0, PH_FREE);
    add_op(MODE_PEEK_BACK,  '0, PH_FREE);
    add_op(MODE_UNUSED,     32'sh1234_5678, PH_FREE);
    add_op(MODE_PUSH_FRONT, 32'sh7fff_ffff, PH_FREE);
    add_op(MODE_PUSH_BACK,  32'sh8000_0000, PH_FREE);
    add_op(MODE_ORDERED,    '0, PH_FREE);
    add_op(MODE_ORDERED,    '0, PH_FREE);
    add_op(MODE_ORDERED,    -32'sd1, PH_FREE);
    add_op(MODE_ORDERED,    32'sh7fff_ffff, PH_FREE);
    add_op(MODE_ORDERED,    32'sh8000_0000, PH_FREE);
    add_op(MODE_PEEK_FRONT, '0, PH_FREE);
    add_op(MODE_PEEK_BACK,  '0, PH_FREE);
    add_op(MODE_UNUSED,     -32'sd1, PH_FREE);
    add_op(MODE_POP_BACK,   '0, PH_FREE);
    add_op(MODE_POP_FRONT,  '0, PH_FREE);
    add_op(MODE_PUSH_FRONT, 32'sh5555_5555, PH_FREE);
    add_op(MODE_PUSH_BACK,  32'shaaaa_aaaa, PH_FREE);
    add_op(MODE_ORDERED,    32'sh5555_5555, PH_FREE);

    // Random: alternate filling and draining stretches so full and empty recur.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      filling = 1'b1;
      stretch = $urandom_range(20, 40);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (stretch == 0) begin
          filling = !filling;
          stretch = $urandom_range(20, 40);
        end
        stretch--;
        add_op(pick_mode(filling), pick_value(), ph);
      end
    end

    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (accepted_ops == total_ops);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations with %0d results checked; deepest fill %0d of %0d.",
             accepted_ops, results_seen, max_fill, LIST_DEPTH);
    $display("Saw %0d refused inserts and %0d empty-list answers across four handshake phases.",
             full_refusals, empty_answers);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results still outstanding.", expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
